FILE: hw/rtl/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types, constants and a helper function of the stepper speed ramp
// generator: command codes, microstep tables and the set-speed handoff.
// ----------------------------------------------------------------------------
package srg_pkg;

	// Default clock of the step timer source, in Hz.
	localparam int unsigned CPU_CLOCK_HZ_DEF = 16000000;

	// Width of the bit-serial divider; covers step-rate numerators,
	// the timer clock and the ramp divisor (frequency times seconds).
	localparam int unsigned DIV_W = 40;

	// Field widths.
	localparam int unsigned RPM_W    = 16;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned CMD_W    = 2;
	// Step frequency: 65535 rpm * 3200 steps / 60 stays below 2^22.
	localparam int unsigned FREQ_W   = 22;
	// Ramp divisor: frequency times a 16-bit second count.
	localparam int unsigned PROD_W   = FREQ_W + 16;

	// Full steps per turn; finer modes double it per mode step.
	localparam logic [7:0] FULL_STEPS   = 8'd200;
	localparam logic [5:0] SECS_PER_MIN = 6'd60;
	localparam int unsigned TIMER_PRESCALE = 16;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SPEED = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DIR   = 2'd3;

	// Ramp kinds.
	localparam logic [KIND_W-1:0] RAMP_NONE = 2'd0;
	localparam logic [KIND_W-1:0] RAMP_UP   = 2'd1;
	localparam logic [KIND_W-1:0] RAMP_SLOW = 2'd2;

	// Microstep modes.
	localparam logic [MODE_W-1:0] MODE_FULL      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_HALF      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_QUARTER   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_EIGHTH    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SIXTEENTH = 3'd4;

	// Register byte address of the microstep mode register.
	localparam logic [2:0] ADDR_MODE = 3'd0;

	// Request handed to the set-speed sequencer.
	typedef struct packed {
		logic [RPM_W-1:0]  rpm;
		logic [15:0]       secs;
		logic [RPM_W-1:0]  last_rpm;
		logic [MODE_W-1:0] mode;
	} srg_req_t;

	// Result returned by the set-speed sequencer.
	typedef struct packed {
		logic [PERIOD_W-1:0] period_cur;
		logic [PERIOD_W-1:0] period_tgt;
		logic [PERIOD_W-1:0] delta;
		logic [KIND_W-1:0]   kind;
	} srg_res_t;

	// Driver mode pins (MS3, MS2, MS1) for each microstep mode.
	function automatic logic [MODE_W-1:0] mode_pins(input logic [MODE_W-1:0] mode);
		logic [MODE_W-1:0] pins;
		case (mode)
			MODE_HALF:      pins = 3'b001;
			MODE_QUARTER:   pins = 3'b010;
			MODE_EIGHTH:    pins = 3'b011;
			MODE_SIXTEENTH: pins = 3'b111;
			default:        pins = 3'b000;
		endcase
		return pins;
	endfunction

endpackage

FILE: hw/rtl/srg_div.sv
// ----------------------------------------------------------------------------
// srg_div
// Bit-serial restoring divider: one quotient bit per cycle, the dividend
// shifting out of the quotient register while the remainder builds up.
// ----------------------------------------------------------------------------
module srg_div
	import srg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic             done,
	output logic [DIV_W-1:0] quo
);

	localparam int unsigned CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] den_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W:0]   rem_q;

	logic [DIV_W:0]   rem_shift;
	logic             fits;

	// One restoring step: bring down the next dividend bit and try a subtract.
	assign rem_shift = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
	assign fits      = rem_shift >= {1'b0, den_q};

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			quo_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_shift - {1'b0, den_q}) : rem_shift;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: hw/rtl/srg_seq.sv
// ----------------------------------------------------------------------------
// srg_seq
// Set-speed sequencer: turns the old and new speed into compare periods
// and derives the per-step period change, running every division through
// one shared bit-serial divider.
// ----------------------------------------------------------------------------
module srg_seq
	import srg_pkg::*;
#(
	parameter int unsigned CPU_CLOCK_HZ = CPU_CLOCK_HZ_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  srg_req_t req,
	output logic     busy,
	output logic     done,
	output srg_res_t res
);

	localparam logic [DIV_W-1:0] TIMER_HZ = DIV_W'(CPU_CLOCK_HZ / TIMER_PRESCALE);

	// Sequencer steps.
	localparam logic [2:0] OP_FNEW  = 3'd0;
	localparam logic [2:0] OP_FOLD  = 3'd1;
	localparam logic [2:0] OP_PNEW  = 3'd2;
	localparam logic [2:0] OP_POLD  = 3'd3;
	localparam logic [2:0] OP_MUL   = 3'd4;
	localparam logic [2:0] OP_DELTA = 3'd5;

	logic                busy_q;
	logic                done_q;
	logic                wait_q;
	logic [2:0]          op_q;
	srg_req_t            req_q;
	logic [FREQ_W-1:0]   fnew_q;
	logic [FREQ_W-1:0]   fold_q;
	logic [PERIOD_W-1:0] pnew_q;
	logic [PERIOD_W-1:0] pold_q;
	logic [PROD_W-1:0]   prod_q;
	logic [PERIOD_W-1:0] gap_q;
	srg_res_t            res_q;

	logic             div_start;
	logic [DIV_W-1:0] div_num;
	logic [DIV_W-1:0] div_den;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;
	logic             rising;
	logic [23:0]      steps_base;

	// Compare period from a step frequency and the timer quotient.
	function automatic logic [PERIOD_W-1:0] to_period(input logic [FREQ_W-1:0] f,
			input logic [DIV_W-1:0] q);
		logic [DIV_W-1:0] qm;
		logic [PERIOD_W-1:0] p;
		qm = q - DIV_W'(1);
		if (f == '0) begin
			p = '1;
		end else if (q == '0) begin
			p = '0;
		end else if (qm > DIV_W'(16'hFFFF)) begin
			p = '1;
		end else begin
			p = qm[PERIOD_W-1:0];
		end
		return p;
	endfunction

	assign rising = req_q.last_rpm < req_q.rpm;

	// Operand selection for the shared divider.
	always_comb begin
		steps_base = 24'(req_q.rpm) * 24'(FULL_STEPS);
		div_num    = '0;
		div_den    = '0;
		unique case (op_q)
			OP_FNEW: begin
				steps_base = 24'(req_q.rpm) * 24'(FULL_STEPS);
				div_num    = DIV_W'(steps_base) << req_q.mode;
				div_den    = DIV_W'(SECS_PER_MIN);
			end
			OP_FOLD: begin
				steps_base = 24'(req_q.last_rpm) * 24'(FULL_STEPS);
				div_num    = DIV_W'(steps_base) << req_q.mode;
				div_den    = DIV_W'(SECS_PER_MIN);
			end
			OP_PNEW: begin
				div_num = TIMER_HZ;
				div_den = DIV_W'(fnew_q);
			end
			OP_POLD: begin
				div_num = TIMER_HZ;
				div_den = DIV_W'(fold_q);
			end
			OP_DELTA: begin
				div_num = DIV_W'(gap_q);
				div_den = DIV_W'(prod_q);
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	assign div_start = busy_q && !wait_q && (op_q != OP_MUL);

	srg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			wait_q <= 1'b0;
			op_q   <= OP_FNEW;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				wait_q <= 1'b0;
				op_q   <= OP_FNEW;
			end else if (busy_q) begin
				if (op_q == OP_MUL) begin
					op_q <= OP_DELTA;
				end else if (!wait_q) begin
					wait_q <= 1'b1;
				end else if (div_done) begin
					wait_q <= 1'b0;
					if (op_q == OP_DELTA) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						op_q <= op_q + 3'd1;
					end
				end
			end
		end
	end

	// Intermediate results.
	always_ff @(posedge clk) begin
		if (start) begin
			req_q <= req;
		end
		if (busy_q && op_q == OP_MUL) begin
			prod_q <= PROD_W'(rising ? fnew_q : fold_q) * PROD_W'(req_q.secs);
			gap_q  <= (pold_q >= pnew_q) ? (pold_q - pnew_q) : (pnew_q - pold_q);
		end
		if (busy_q && wait_q && div_done) begin
			unique case (op_q)
				OP_FNEW: fnew_q <= div_quo[FREQ_W-1:0];
				OP_FOLD: fold_q <= div_quo[FREQ_W-1:0];
				OP_PNEW: pnew_q <= to_period(fnew_q, div_quo);
				OP_POLD: pold_q <= to_period(fold_q, div_quo);
				OP_DELTA: begin
					res_q.period_cur <= pold_q;
					res_q.period_tgt <= pnew_q;
					res_q.kind       <= rising ? RAMP_UP : RAMP_SLOW;
					res_q.delta      <= (prod_q == '0) ? gap_q : div_quo[PERIOD_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: hw/rtl/stepper_speed_ramp_generator_core.sv
// ----------------------------------------------------------------------------
// stepper_speed_ramp_generator_core
// Step-pulse generator with a linear speed ramp for a stepper driver.
// ----------------------------------------------------------------------------
// Tick, stop and set-direction items are finished in the cycle they are taken,
// so ticks can stream in every cycle while the result stream is not held and no
// set-speed item is in work. A set-speed item takes longer: its four
// speed-to-period conversions and the ramp step division run in turn through
// one bit-serial divider that produces one quotient bit per cycle. Every item
// yields exactly one result item; the next input item is taken when no set-speed
// item is still being worked on and the result register is free or is being
// emptied in the same cycle.
module stepper_speed_ramp_generator_core
	import srg_pkg::*;
#(
	parameter int unsigned CPU_CLOCK_HZ = CPU_CLOCK_HZ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input item stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // target_rpm[15:0], ramp_seconds[31:16], direction_in[32]
	input  logic [1:0]  s_tuser,   // command[1:0]
	// Result item stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // step_level[0], direction_level[1], mode_pins[4:2],
	                               // counting[5], period_now[21:6], period_goal[37:22],
	                               // ramping[39:38]
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0]         tick_q;
	logic [PERIOD_W-1:0] cur_q;
	logic [PERIOD_W-1:0] tgt_q;
	logic [PERIOD_W-1:0] delta_q;
	logic [KIND_W-1:0]   kind_q;
	logic [RPM_W-1:0]    last_rpm_q;
	logic                run_q;
	logic                step_q;
	logic                dir_q;
	logic [MODE_W-1:0]   mode_q;
	logic                out_valid_q;
	logic [39:0]         out_data_q;

	logic [15:0]         tick_d;
	logic [PERIOD_W-1:0] cur_d;
	logic [PERIOD_W-1:0] tgt_d;
	logic [PERIOD_W-1:0] delta_d;
	logic [KIND_W-1:0]   kind_d;
	logic [RPM_W-1:0]    last_rpm_d;
	logic                run_d;
	logic                step_d;
	logic                dir_d;

	logic                in_acc;
	logic [CMD_W-1:0]    cmd;
	logic                seq_start;
	logic                seq_busy;
	logic                seq_done;
	srg_req_t            seq_req;
	srg_res_t            seq_res;
	logic                out_load;
	logic                cfg_wr;

	// Input handshake: one item at a time, result register must be free.
	// The cycle in which a set-speed item finishes belongs to that item.
	assign s_tready  = !seq_busy && !seq_done && (!out_valid_q || m_tready);
	assign in_acc    = s_tvalid && s_tready;
	assign cmd       = s_tuser;
	assign seq_start = in_acc && (cmd == CMD_SPEED);

	assign seq_req.rpm      = s_tdata[15:0];
	assign seq_req.secs     = s_tdata[31:16];
	assign seq_req.last_rpm = last_rpm_q;
	assign seq_req.mode     = mode_q;

	srg_seq #(
		.CPU_CLOCK_HZ (CPU_CLOCK_HZ)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seq_start),
		.req    (seq_req),
		.busy   (seq_busy),
		.done   (seq_done),
		.res    (seq_res)
	);

	// Next state for the accepted item or the finished set-speed item.
	always_comb begin
		tick_d     = tick_q;
		cur_d      = cur_q;
		tgt_d      = tgt_q;
		delta_d    = delta_q;
		kind_d     = kind_q;
		last_rpm_d = last_rpm_q;
		run_d      = run_q;
		step_d     = step_q;
		dir_d      = dir_q;
		if (in_acc) begin
			unique case (cmd)
				CMD_TICK: begin
					if (run_q) begin
						if (tick_q == cur_q) begin
							tick_d = '0;
							step_d = !step_q;
							// Move the period toward its target, clamped there.
							if (kind_q == RAMP_UP && cur_q > tgt_q) begin
								cur_d = ((cur_q - tgt_q) <= delta_q) ? tgt_q : (cur_q - delta_q);
							end else if (kind_q == RAMP_SLOW && cur_q < tgt_q) begin
								cur_d = ((tgt_q - cur_q) <= delta_q) ? tgt_q : (cur_q + delta_q);
							end
						end else begin
							tick_d = tick_q + 16'd1;
						end
					end
				end
				CMD_SPEED: begin
					last_rpm_d = s_tdata[15:0];
				end
				CMD_STOP: begin
					run_d  = 1'b0;
					tick_d = '0;
					kind_d = RAMP_NONE;
				end
				CMD_DIR: begin
					dir_d = s_tdata[32];
				end
				default: ;
			endcase
		end
		if (seq_done) begin
			cur_d   = seq_res.period_cur;
			tgt_d   = seq_res.period_tgt;
			delta_d = seq_res.delta;
			kind_d  = seq_res.kind;
			run_d   = 1'b1;
		end
	end

	assign out_load = (in_acc && cmd != CMD_SPEED) || seq_done;

	// Block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			cur_q      <= '0;
			tgt_q      <= '0;
			delta_q    <= '0;
			kind_q     <= RAMP_NONE;
			last_rpm_q <= '0;
			run_q      <= 1'b0;
			step_q     <= 1'b0;
			dir_q      <= 1'b0;
		end else begin
			tick_q     <= tick_d;
			cur_q      <= cur_d;
			tgt_q      <= tgt_d;
			delta_q    <= delta_d;
			kind_q     <= kind_d;
			last_rpm_q <= last_rpm_d;
			run_q      <= run_d;
			step_q     <= step_d;
			dir_q      <= dir_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {kind_d, tgt_d, cur_d, run_d, mode_pins(mode_q), dir_d, step_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Configuration register; undefined modes are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ADDR_MODE[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FULL;
		end else if (cfg_wr && pwdata[MODE_W-1:0] <= MODE_SIXTEENTH) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == ADDR_MODE[2]) ? {29'd0, mode_q} : 32'd0;

`ifndef SYNTHESIS
	// A finished set-speed item always shows up as a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) seq_done |=> m_tvalid)
		else $error("set-speed result not presented");

	// The counter only stops on a stop item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_q) |-> $past(in_acc && cmd == CMD_STOP))
		else $error("counter stopped without a stop item");

	// The microstep mode never holds an undefined code.
	assert property (@(posedge clk) disable iff (!arst_n) mode_q <= MODE_SIXTEENTH)
		else $error("undefined microstep mode stored");
`endif

endmodule
